// File: src/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared definitions for the humidity and temperature converter
// Field widths, fixed-point coefficients and the item types that pass
// between the front end, the queue and the arithmetic pipeline.
// ----------------------------------------------------------------------------
package htc_pkg;

   // Field widths.
   localparam int RAW_T_W = 14;
   localparam int RH_W    = 12;
   localparam int MAG_W   = 14;
   localparam int TDIFF_W = 15;
   localparam int FIELD_W = 7;
   localparam int HUND_W  = 14;

   // Width of the humidity accumulator (value times 100, scaled by 2^24).
   localparam int H_W    = 42;
   localparam int HQ_W   = H_W - 24;
   localparam int SQ_W   = 44;
   localparam int LIN_W  = 38;
   localparam int COEF_W = 23;
   localparam int COMP_W = 38;

   // Default depth of the queue between front end and pipeline.
   localparam int FIFO_DEPTH_DEF = 4;

   // Temperature offsets: tc = raw - 4010, and tc - 2500 = raw - 6510.
   localparam logic signed [TDIFF_W-1:0] TEMP_OFFSET  = 15'sd4010;
   localparam logic signed [TDIFF_W-1:0] TDIFF_OFFSET = 15'sd6510;

   // Humidity coefficients, all multiplied by 100 and scaled by 2^24.
   localparam longint     C1_X100 = -64'sd3433960600;
   localparam logic [25:0] C2_X100 = 26'd61572400;
   // 100 * 6853 for the square term, which is scaled by 2^32.
   localparam logic [19:0] SQ_K    = 20'd685300;
   localparam logic [17:0] T1_K    = 18'd167772;
   localparam logic [10:0] T2_K    = 11'd1342;

   // Division by 100 as a multiplication by a reciprocal; exact below 2^14.
   localparam logic [12:0] DIV100_K  = 13'd5243;
   localparam int          DIV100_SH = 19;
   localparam int          DIV_P_W   = 27;
   localparam logic [6:0]  HUNDRED   = 7'd100;

   // Humidity limits in hundredths of a percent.
   localparam logic signed [HQ_W-1:0] HUM_LOW   = 18'sd10;
   localparam logic signed [HQ_W-1:0] HUM_HIGH  = 18'sd10000;
   localparam logic [HUND_W-1:0]      HUM_FLOOR = 14'd10;
   localparam logic [HUND_W-1:0]      HUM_CLAMP = 14'd9990;

   // Packed bus widths.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // A classified measurement, as queued for the pipeline.
   typedef struct packed {
      logic                      neg;
      logic [MAG_W-1:0]          mag;
      logic signed [TDIFF_W-1:0] tdiff;
      logic [RH_W-1:0]           rh;
   } meas_type;

   // A finished result.
   typedef struct packed {
      logic               temp_negative;
      logic [FIELD_W-1:0] temp_whole;
      logic [FIELD_W-1:0] temp_hundredths;
      logic [FIELD_W-1:0] humidity_whole;
      logic [FIELD_W-1:0] humidity_hundredths;
   } result_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// File: src/humidity_temperature_convert.sv
// ----------------------------------------------------------------------------
// humidity_temperature_convert: raw sensor counts to temperature and humidity
// Converts a raw temperature and humidity count pair into a signed
// temperature and a compensated, clamped relative humidity.
// ----------------------------------------------------------------------------
// The block takes one measurement transaction per clock cycle while its queue
// has room and returns one result transaction for each, in order. A result
// passes through the input stage register, a queue slot and the stages of the
// arithmetic pipeline, whose stages hold the fixed-point multiplications, the
// wide sum of the humidity terms, the clamp and the assembly of the result.
// A queue, four entries deep by default, sits between the input stage and the
// pipeline, so input keeps flowing while the output side stalls, until the
// queue and the input stage are full.
module humidity_temperature_convert #(
   parameter int FIFO_DEPTH = htc_pkg::FIFO_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: raw_temperature [13:0], raw_humidity [25:14], zeros above
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [htc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: temp_negative [0], temp_whole [7:1], temp_hundredths [14:8],
   // humidity_whole [21:15], humidity_hundredths [28:22], zeros above
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [htc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   htc_pkg::fifo_stat_type fifo_stat;
   htc_pkg::meas_type      front_item;
   htc_pkg::meas_type      head_item;
   htc_pkg::result_type    result;
   logic                   push;
   logic                   pop;

   // Input stage.
   htc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .in_raw_temperature (req_tdata[13:0]),
      .in_raw_humidity    (req_tdata[25:14]),
      .fifo_stat          (fifo_stat),
      .push               (push),
      .item               (front_item)
   );

   // Queue between input stage and pipeline.
   htc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (fifo_stat)
   );

   // Arithmetic pipeline.
   htc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .fifo_empty (fifo_stat.empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {3'b000,
                       result.humidity_hundredths,
                       result.humidity_whole,
                       result.temp_hundredths,
                       result.temp_whole,
                       result.temp_negative};

   // The queue never reads an empty slot.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("pop from empty queue");

   // Full and empty are never reported together.
   a_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(fifo_stat.full && fifo_stat.empty))
      else $error("queue status inconsistent");

   // Humidity stays within the clamped range.
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:15] <= 7'd99) && (rsp_tdata[28:22] <= 7'd99))
      else $error("humidity out of range");

   // Hundredths of the temperature are a proper remainder, and the whole part is at most 124.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:8] <= 7'd99) && (rsp_tdata[7:1] <= 7'd124))
      else $error("temperature out of range");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// File: src/htc_front.sv
// ----------------------------------------------------------------------------
// htc_front: input stage
// Accepts raw measurements, works out the signed temperature, its sign and
// magnitude and the offset used by the compensation, and hands the item on.
// ----------------------------------------------------------------------------
module htc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [htc_pkg::RAW_T_W-1:0]     in_raw_temperature,
   input  logic [htc_pkg::RH_W-1:0]        in_raw_humidity,
   input  htc_pkg::fifo_stat_type          fifo_stat,
   output logic                            push,
   output htc_pkg::meas_type               item
);

   logic              valid_ff, valid_in;
   htc_pkg::meas_type item_ff, item_in;
   logic signed [htc_pkg::TDIFF_W-1:0] tc;
   logic signed [htc_pkg::TDIFF_W-1:0] tc_abs;

   // Hand the held item to the queue whenever it has room.
   assign push     = valid_ff && !fifo_stat.full;
   assign in_ready = !valid_ff || push;
   assign item     = item_ff;

   // Classify the temperature into sign and magnitude and form the compensation offset.
   always_comb begin
      tc            = $signed({1'b0, in_raw_temperature}) - htc_pkg::TEMP_OFFSET;
      tc_abs        = tc[htc_pkg::TDIFF_W-1] ? -tc : tc;
      item_in.neg   = tc[htc_pkg::TDIFF_W-1];
      item_in.mag   = tc_abs[htc_pkg::MAG_W-1:0];
      item_in.tdiff = $signed({1'b0, in_raw_temperature}) - htc_pkg::TDIFF_OFFSET;
      item_in.rh    = in_raw_humidity;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: src/htc_fifo.sv
// ----------------------------------------------------------------------------
// htc_fifo: short queue between the front end and the pipeline
// A small circular buffer of classified items; the head is always visible.
// ----------------------------------------------------------------------------
module htc_fifo #(
   parameter int DEPTH = htc_pkg::FIFO_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  htc_pkg::meas_type      push_item,
   input  logic                   pop,
   output htc_pkg::meas_type      head_item,
   output htc_pkg::fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   htc_pkg::meas_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/htc_back.sv
// ----------------------------------------------------------------------------
// htc_back: arithmetic pipeline
// Six stages that evaluate the compensated humidity polynomial, clamp it and
// split both values into whole and hundredths parts. The whole pipeline
// advances together whenever its output register is free or being taken.
// ----------------------------------------------------------------------------
module htc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  htc_pkg::meas_type    head_item,
   input  logic                 fifo_empty,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output htc_pkg::result_type  out_result
);

   localparam int N_STAGE = 6;

   logic [N_STAGE-1:0] valid_ff, valid_in;
   logic               advance;

   // Stage 1: square, linear term and compensation slope.
   logic [23:0]                         s1_rhsq_ff, s1_rhsq_in;
   logic [htc_pkg::LIN_W-1:0]           s1_lin_ff, s1_lin_in;
   logic [htc_pkg::COEF_W-1:0]          s1_coef_ff, s1_coef_in;
   logic signed [htc_pkg::TDIFF_W-1:0]  s1_tdiff_ff;
   logic                                s1_neg_ff;
   logic [htc_pkg::MAG_W-1:0]           s1_mag_ff;

   // Stage 2: wide products and temperature quotient.
   logic [htc_pkg::SQ_W-9:0]            s2_sq_ff, s2_sq_in;
   logic signed [htc_pkg::COMP_W-1:0]   s2_comp_ff, s2_comp_in;
   logic signed [htc_pkg::H_W-1:0]      s2_base_ff, s2_base_in;
   logic [htc_pkg::DIV_P_W-1:0]         s2_tprod;
   logic [htc_pkg::FIELD_W-1:0]         s2_tq_ff, s2_tq_in;
   logic                                s2_neg_ff;
   logic [htc_pkg::MAG_W-1:0]           s2_mag_ff;

   // Stage 3: accumulated humidity and temperature remainder.
   logic signed [htc_pkg::H_W-1:0]      s3_h_ff, s3_h_in;
   logic [htc_pkg::MAG_W-1:0]           s3_trem;
   logic [htc_pkg::FIELD_W-1:0]         s3_tr_ff, s3_tr_in;
   logic [htc_pkg::FIELD_W-1:0]         s3_tq_ff;
   logic                                s3_neg_ff;

   // Stage 4: clamped humidity in hundredths.
   logic signed [htc_pkg::HQ_W-1:0]     s4_hq;
   logic [htc_pkg::HUND_W-1:0]          s4_hund_ff, s4_hund_in;
   logic [htc_pkg::FIELD_W-1:0]         s4_tq_ff, s4_tr_ff;
   logic                                s4_neg_ff;

   // Stage 5: humidity quotient.
   logic [htc_pkg::DIV_P_W-1:0]         s5_hprod;
   logic [htc_pkg::FIELD_W-1:0]         s5_hq_ff, s5_hq_in;
   logic [htc_pkg::HUND_W-1:0]          s5_hund_ff;
   logic [htc_pkg::FIELD_W-1:0]         s5_tq_ff, s5_tr_ff;
   logic                                s5_neg_ff;

   // Stage 6: output register.
   logic [htc_pkg::HUND_W-1:0]          s6_hrem;
   htc_pkg::result_type                 s6_res_ff, s6_res_in;

   // The pipeline moves as one; it takes a queued item on every move while the queue is not empty.
   assign advance    = !valid_ff[N_STAGE-1] || out_ready;
   assign pop        = advance && !fifo_empty;
   assign out_valid  = valid_ff[N_STAGE-1];
   assign out_result = s6_res_ff;

   always_comb begin
      valid_in = {valid_ff[N_STAGE-2:0], pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1 arithmetic.
   always_comb begin
      s1_rhsq_in = 24'(head_item.rh) * 24'(head_item.rh);
      s1_lin_in  = htc_pkg::LIN_W'(htc_pkg::C2_X100) * htc_pkg::LIN_W'(head_item.rh);
      s1_coef_in = htc_pkg::COEF_W'(htc_pkg::T1_K)
                 + htc_pkg::COEF_W'(htc_pkg::T2_K) * htc_pkg::COEF_W'(head_item.rh);
   end

   // Stage 2 arithmetic.
   always_comb begin
      logic [htc_pkg::SQ_W-1:0] sq_full;
      sq_full    = htc_pkg::SQ_W'(htc_pkg::SQ_K) * htc_pkg::SQ_W'(s1_rhsq_ff);
      s2_sq_in   = sq_full[htc_pkg::SQ_W-1:8];
      s2_comp_in = htc_pkg::COMP_W'(s1_tdiff_ff)
                 * htc_pkg::COMP_W'($signed({1'b0, s1_coef_ff}));
      s2_base_in = htc_pkg::H_W'(htc_pkg::C1_X100)
                 + htc_pkg::H_W'($signed({1'b0, s1_lin_ff}));
      s2_tprod   = htc_pkg::DIV_P_W'(s1_mag_ff) * htc_pkg::DIV_P_W'(htc_pkg::DIV100_K);
      s2_tq_in   = s2_tprod[htc_pkg::DIV100_SH +: htc_pkg::FIELD_W];
   end

   // Stage 3 arithmetic.
   always_comb begin
      s3_h_in  = s2_base_ff
               - htc_pkg::H_W'($signed({1'b0, s2_sq_ff}))
               + htc_pkg::H_W'(s2_comp_ff);
      s3_trem  = s2_mag_ff
               - htc_pkg::MAG_W'(s2_tq_ff) * htc_pkg::MAG_W'(htc_pkg::HUNDRED);
      s3_tr_in = s3_trem[htc_pkg::FIELD_W-1:0];
   end

   // Stage 4: truncate to hundredths and clamp to the valid range.
   always_comb begin
      s4_hq = s3_h_ff[htc_pkg::H_W-1:24];
      if (s4_hq < htc_pkg::HUM_LOW) begin
         s4_hund_in = htc_pkg::HUM_FLOOR;
      end else if (s4_hq >= htc_pkg::HUM_HIGH) begin
         s4_hund_in = htc_pkg::HUM_CLAMP;
      end else begin
         s4_hund_in = s4_hq[htc_pkg::HUND_W-1:0];
      end
   end

   // Stage 5 arithmetic.
   always_comb begin
      s5_hprod = htc_pkg::DIV_P_W'(s4_hund_ff) * htc_pkg::DIV_P_W'(htc_pkg::DIV100_K);
      s5_hq_in = s5_hprod[htc_pkg::DIV100_SH +: htc_pkg::FIELD_W];
   end

   // Stage 6: assemble the result.
   always_comb begin
      s6_hrem = s5_hund_ff
              - htc_pkg::HUND_W'(s5_hq_ff) * htc_pkg::HUND_W'(htc_pkg::HUNDRED);
      s6_res_in.temp_negative       = s5_neg_ff;
      s6_res_in.temp_whole          = s5_tq_ff;
      s6_res_in.temp_hundredths     = s5_tr_ff;
      s6_res_in.humidity_whole      = s5_hq_ff;
      s6_res_in.humidity_hundredths = s6_hrem[htc_pkg::FIELD_W-1:0];
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rhsq_ff  <= s1_rhsq_in;
         s1_lin_ff   <= s1_lin_in;
         s1_coef_ff  <= s1_coef_in;
         s1_tdiff_ff <= head_item.tdiff;
         s1_neg_ff   <= head_item.neg;
         s1_mag_ff   <= head_item.mag;

         s2_sq_ff    <= s2_sq_in;
         s2_comp_ff  <= s2_comp_in;
         s2_base_ff  <= s2_base_in;
         s2_tq_ff    <= s2_tq_in;
         s2_neg_ff   <= s1_neg_ff;
         s2_mag_ff   <= s1_mag_ff;

         s3_h_ff     <= s3_h_in;
         s3_tr_ff    <= s3_tr_in;
         s3_tq_ff    <= s2_tq_ff;
         s3_neg_ff   <= s2_neg_ff;

         s4_hund_ff  <= s4_hund_in;
         s4_tq_ff    <= s3_tq_ff;
         s4_tr_ff    <= s3_tr_ff;
         s4_neg_ff   <= s3_neg_ff;

         s5_hq_ff    <= s5_hq_in;
         s5_hund_ff  <= s4_hund_ff;
         s5_tq_ff    <= s4_tq_ff;
         s5_tr_ff    <= s4_tr_ff;
         s5_neg_ff   <= s4_neg_ff;

         s6_res_ff   <= s6_res_in;
      end
   end

endmodule
